FILE: sv/bdps_pkg.sv
// Package: geometry, command codes and sequencer positions for the page stream unit.
package bdps_pkg;

  localparam int ROW_BYTES = 16;
  localparam int PAGES     = 8;

  localparam int GRP_W     = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int LANES     = 7;
  localparam int RAM_W     = LANES * 8;

  localparam logic [7:0] CMD_SET_PAGE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO   = 8'h00 & 8'h0F;
  localparam logic [7:0] CMD_COL_HI   = 8'h10;

  localparam logic [3:0] POS_SET_PAGE   = 4'd0;
  localparam logic [3:0] POS_COL_LO     = 4'd1;
  localparam logic [3:0] POS_COL_HI     = 4'd2;
  localparam logic [3:0] POS_FIRST_DATA = 4'd3;
  localparam logic [3:0] POS_LAST       = 4'd10;

  localparam int TUSER_CMD   = 0;
  localparam int TUSER_START = 1;

endpackage

FILE: sv/bitmap_to_display_page_stream_unit.sv
// Top level: buffers seven rows of a band and streams page-format bytes.
//
// channel | dir | tdata                 | tuser                          | tlast
// in_     | in  | [7:0] pixel_byte      | -                              | -
// out_    | out | [7:0] out_byte        | [0] is_command [1] write_start | last
//
// Rows 0..6 of a band: one beat per cycle, written into a 16 x 56-bit band RAM lane.
// Eighth-row beat: RAM read, then sequencer load, then 8 beats out, 11 with
// the page commands; the first out beat passes the RAM read and load registers.
// The sequencer emits one beat per cycle unless stalled and paces eighth-row beats.
// Any in beat is held off while an eighth-row beat waits for the sequencer.
// Synchronous active-low reset clears counters and sequencer; RAM needs no clearing.
module bitmap_to_display_page_stream_unit
  import bdps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] pixel_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] is_command, [1] write_start
  output logic       out_tlast
);

  localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(ROW_BYTES - 1);
  localparam logic [5:0]       ROW_LAST = 6'(PAGES * 8 - 1);

  logic [RAM_W-1:0] mem [ROW_BYTES];
  logic [RAM_W-1:0] rd_data_r;

  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic [5:0]       row_r, row_nxt;
  logic             pend_r, pend_nxt;
  logic [7:0]       px_r;
  logic             grp0_r;
  logic [2:0]       band_r;
  logic [2:0]       seq_band_r;
  logic             busy_r, busy_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [7:0]       data_r [8];
  logic [7:0]       trans [8];
  logic [7:0]       rows [8];
  logic [2:0]       data_idx;

  logic in_acc, eighth, wr_en, rd_en, seq_free, load, at_last;

  assign in_acc   = in_tvalid && in_tready;
  assign eighth   = (row_r[2:0] == 3'd7);
  assign wr_en    = in_acc && !eighth;
  assign rd_en    = in_acc && eighth;
  assign at_last  = (pos_r == POS_LAST);
  assign seq_free = !busy_r || (out_tready && at_last);
  assign load     = pend_r && seq_free;
  assign in_tready = !pend_r || seq_free;

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (wr_en && (row_r[2:0] == 3'(l))) begin
        mem[grp_r][l*8 +: 8] <= in_tdata;
      end
    end
    if (rd_en) begin
      rd_data_r <= mem[grp_r];
      px_r      <= in_tdata;
      grp0_r    <= (grp_r == '0);
      band_r    <= row_r[5:3];
    end
  end

  always_comb begin
    grp_nxt = grp_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (grp_r >= GRP_LAST) begin
        grp_nxt = '0;
        row_nxt = (row_r >= ROW_LAST) ? 6'd0 : row_r + 6'd1;
      end else begin
        grp_nxt = grp_r + 1'b1;
      end
    end
  end

  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      rows[b] = rd_data_r[b*8 +: 8];
    end
    rows[7] = px_r;
    for (int k = 0; k < 8; k++) begin
      for (int b = 0; b < 8; b++) begin
        trans[k][b] = rows[b][k];
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (rd_en) begin
      pend_nxt = 1'b1;
    end else if (load) begin
      pend_nxt = 1'b0;
    end
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    if (load) begin
      busy_nxt = 1'b1;
      pos_nxt  = grp0_r ? POS_SET_PAGE : POS_FIRST_DATA;
    end else if (busy_r && out_tready) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r  <= '0;
      row_r  <= '0;
      pend_r <= 1'b0;
      busy_r <= 1'b0;
      pos_r  <= POS_SET_PAGE;
    end else begin
      grp_r  <= grp_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seq_band_r <= band_r;
      for (int k = 0; k < 8; k++) begin
        data_r[k] <= trans[k];
      end
    end
  end

  assign data_idx = 3'(pos_r - POS_FIRST_DATA);

  always_comb begin
    out_tdata = data_r[data_idx];
    out_tuser = '0;
    unique case (pos_r)
      POS_SET_PAGE: begin
        out_tdata = CMD_SET_PAGE | {5'd0, seq_band_r};
        out_tuser[TUSER_CMD]   = 1'b1;
        out_tuser[TUSER_START] = 1'b1;
      end
      POS_COL_LO: begin
        out_tdata = CMD_COL_LO;
        out_tuser[TUSER_CMD] = 1'b1;
      end
      POS_COL_HI: begin
        out_tdata = CMD_COL_HI;
        out_tuser[TUSER_CMD] = 1'b1;
      end
      default: begin
        out_tuser[TUSER_START] = (pos_r == POS_FIRST_DATA);
      end
    endcase
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = at_last;

endmodule

FILE: sv/bdps_checker.sv
// Checker: port-level properties of the page stream unit, bound to the top level.
module bdps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("out beat changed while stalled");

  a_set_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && out_tuser[1] |-> out_tdata[7:3] == 5'b10110)
    else $error("set-page command malformed");

  a_col_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && !out_tuser[1] |-> out_tdata == 8'h00 || out_tdata == 8'h10)
    else $error("column command malformed");

  a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser[0] && !out_tuser[1])
    else $error("last beat is not a trailing data byte");

endmodule

bind bitmap_to_display_page_stream_unit bdps_checker u_bdps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
